FILE: hw/rtl/priority_ready_queue_defines.svh
// Assertion macros for the priority ready queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define PRQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("prq assertion failed");

// Antecedent this cycle implies consequent next cycle.
`define PRQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prq assertion failed");

`else

`define PRQ_ASSERT(lbl, prop)
`define PRQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/prq_pkg.sv
// Shared types and codes of the priority ready queue.
// No dependencies; imported by every module of the block except prq_ram.
package prq_pkg;

	localparam int MODE_W    = 3;
	localparam int HANDLE_W  = 32;
	localparam int PRIO_IN_W = 8;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 6;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_PRIO = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FIND      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [HANDLE_W-1:0]  item_handle;
		logic [PRIO_IN_W-1:0] item_priority;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [HANDLE_W-1:0]  out_handle;
		logic [PRIO_IN_W-1:0] out_priority;
		logic [OCC_W-1:0]     occupancy;
	} rsp_item_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_LAST,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT_UP,
		WR_SHIFT_DOWN,
		WR_NEW
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	// controller -> datapath
	typedef struct packed {
		logic                capture;
		idx_op_t             idx_op;
		logic                rd_en;
		logic                rd_prev;
		wr_op_t              wr_op;
		cnt_op_t             cnt_op;
		logic                set_found;
		logic                res_wr;
		logic [STATUS_W-1:0] res_status;
		logic                res_data;
		logic                load_rsp;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              empty;
		logic              idx_above_pos;
		logic              idx_last;
		logic              shift_ok;
		logic              hit;
		logic              found;
		logic              rsp_busy;
	} dp_stat_t;

endpackage

FILE: hw/rtl/priority_ready_queue.sv
// Steps: full/empty refusals and odd modes go from check straight to done; pop reads the tail;
// push scans, shifts and inserts; find/remove scan (one read, one evaluate per slot or entry).
// Throughput: one item in flight; next item taken the cycle after its result is registered.
// Results wait in an output register, so a new item is accepted while one is stalled.
// Reset (arst_n low, asynchronous): queue empty, no result pending; slot RAM is not cleared.
// Depends on prq_pkg, prq_ctrl, prq_datapath and prq_ram.
module priority_ready_queue
	import prq_pkg::*;
#(
	parameter int DEPTH     = 32,
	parameter int PRIO_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	// Control/status between the sequencer and the datapath.
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequencer: one state per step of the current operation. A push scans
	// from the head for the first entry not above the new one (head push stops
	// at slot 0), then walks from the tail back to that slot moving entries
	// down; pop reads the tail; find and remove scan from the head, remove
	// closing the gap behind the first matching entry as it goes.
	prq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: operand and count registers, sweep index, the slot RAM
	// (handle and priority in one word), and the result/output registers.
	prq_datapath #(
		.DEPTH    (DEPTH),
		.PRIO_BITS(PRIO_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

FILE: hw/rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the queue slot storage.
module prq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/prq_datapath.sv
// Datapath of the priority ready queue: operand, count, sweep index, slot RAM,
// result and output registers. Depends on prq_pkg, prq_ram and the defines header.
`include "priority_ready_queue_defines.svh"

module prq_datapath
	import prq_pkg::*;
#(
	parameter int DEPTH     = 32,
	parameter int PRIO_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output rsp_item_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = HANDLE_W + PRIO_BITS;

	logic [MODE_W-1:0]    op_mode_q;
	logic [HANDLE_W-1:0]  op_handle_q;
	logic [PRIO_BITS-1:0] op_prio_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        idx_q;
	logic [AW-1:0]        pos_q;
	logic                 found_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [HANDLE_W-1:0]  res_handle_q;
	logic [PRIO_BITS-1:0] res_prio_q;
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [EW-1:0]        ram_wr_data;
	logic [AW-1:0]        ram_rd_addr;
	logic [EW-1:0]        ram_rd_data;
	logic [HANDLE_W-1:0]  rd_handle;
	logic [PRIO_BITS-1:0] rd_prio;

	assign rd_handle = ram_rd_data[PRIO_BITS +: HANDLE_W];
	assign rd_prio   = ram_rd_data[PRIO_BITS-1:0];

	// operand capture; head push carries priority zero
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_mode_q   <= req.mode;
			op_handle_q <= req.item_handle;
			op_prio_q   <= (req.mode == MODE_PUSH_HEAD) ? '0 : PRIO_BITS'(req.item_priority);
		end
		// slot where the first match or the insertion point was seen
		if (cmd.set_found) begin
			pos_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
			case (cmd.idx_op)
				IDX_COUNT: idx_q <= AW'(count_q);
				IDX_LAST:  idx_q <= AW'(count_q - CW'(1));
				IDX_ZERO:  idx_q <= '0;
				IDX_INC:   idx_q <= idx_q + AW'(1);
				IDX_DEC:   idx_q <= idx_q - AW'(1);
				default:   idx_q <= idx_q;
			endcase
			if (cmd.capture) begin
				found_q <= 1'b0;
			end else if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_wr) begin
			res_status_q <= cmd.res_status;
			res_handle_q <= cmd.res_data ? rd_handle : '0;
			res_prio_q   <= cmd.res_data ? rd_prio : '0;
		end
		if (cmd.load_rsp) begin
			rsp_q.status       <= res_status_q;
			rsp_q.out_handle   <= res_handle_q;
			rsp_q.out_priority <= PRIO_IN_W'(res_prio_q);
			rsp_q.occupancy    <= OCC_W'(count_q);
		end
	end

	// push sweeps read the slot below the index
	assign ram_rd_addr = cmd.rd_prev ? idx_q - AW'(1) : idx_q;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q;
		ram_wr_data = ram_rd_data;
		case (cmd.wr_op)
			WR_SHIFT_UP: begin
				ram_wr_en = 1'b1;
			end
			WR_SHIFT_DOWN: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = idx_q - AW'(1);
			end
			WR_NEW: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = {op_handle_q, op_prio_q};
			end
			default: ram_wr_en = 1'b0;
		endcase
	end

	prq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_slots (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	assign stat.mode          = op_mode_q;
	assign stat.full          = (count_q == CW'(DEPTH));
	assign stat.empty         = (count_q == '0);
	assign stat.idx_above_pos = (idx_q == pos_q + AW'(1));
	assign stat.idx_last      = (CW'(idx_q) == count_q - CW'(1));
	assign stat.shift_ok      = (op_mode_q == MODE_PUSH_HEAD) || (rd_prio <= op_prio_q);
	assign stat.hit           = (rd_handle == op_handle_q);
	assign stat.found         = found_q;
	assign stat.rsp_busy      = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PRQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`PRQ_ASSERT(a_no_inc_when_full, (cmd.cnt_op == CNT_INC) |-> !stat.full)
	`PRQ_ASSERT(a_close_gap_after_hit, (cmd.wr_op == WR_SHIFT_DOWN) |-> found_q)

endmodule

FILE: hw/rtl/prq_ctrl.sv
// Controller of the priority ready queue: sequences one operation at a time.
// Depends on prq_pkg and the defines header.
`include "priority_ready_queue_defines.svh"

module prq_ctrl
	import prq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_INS  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       hit_now;

	assign hit_now   = !stat.found && stat.hit;
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.idx_op     = IDX_HOLD;
		cmd.wr_op      = WR_NONE;
		cmd.cnt_op     = CNT_HOLD;
		cmd.res_status = ST_OK;
		state_d        = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				unique case (stat.mode) inside
					MODE_PUSH_HEAD, MODE_PUSH_PRIO: begin
						if (stat.full) begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_DONE;
						end else begin
							// scan from the head for the insertion point
							cmd.idx_op = IDX_ZERO;
							state_d    = stat.empty ? S_INS : S_RD;
						end
					end
					MODE_POP: begin
						if (stat.empty) begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_EMPTY;
							state_d        = S_DONE;
						end else begin
							cmd.idx_op = IDX_LAST;
							state_d    = S_RD;
						end
					end
					MODE_FIND, MODE_REMOVE: begin
						if (stat.empty) begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
							state_d        = S_DONE;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_RD;
						end
					end
					default: begin
						cmd.res_wr = 1'b1;
						state_d    = S_DONE;
					end
				endcase
			end
			S_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_prev = stat.found &&
					((stat.mode == MODE_PUSH_HEAD) || (stat.mode == MODE_PUSH_PRIO));
				state_d     = S_EV;
			end
			S_EV: begin
				unique case (stat.mode) inside
					MODE_PUSH_HEAD, MODE_PUSH_PRIO: begin
						if (stat.found) begin
							// move one entry toward the tail until the gap reaches the slot
							cmd.wr_op  = WR_SHIFT_UP;
							cmd.idx_op = IDX_DEC;
							state_d    = stat.idx_above_pos ? S_INS : S_RD;
						end else if (stat.shift_ok) begin
							// first entry not above the new one: sweep back from the tail
							cmd.set_found = 1'b1;
							cmd.idx_op    = IDX_COUNT;
							state_d       = S_RD;
						end else if (stat.idx_last) begin
							// every entry is above the new one: append at the tail
							cmd.idx_op = IDX_COUNT;
							state_d    = S_INS;
						end else begin
							cmd.idx_op = IDX_INC;
							state_d    = S_RD;
						end
					end
					MODE_POP: begin
						cmd.res_wr   = 1'b1;
						cmd.res_data = 1'b1;
						cmd.cnt_op   = CNT_DEC;
						state_d      = S_DONE;
					end
					default: begin
						// find or remove: scan from head, close gap after first hit
						if (stat.found) begin
							cmd.wr_op = WR_SHIFT_DOWN;
						end
						if (hit_now) begin
							cmd.set_found = 1'b1;
						end
						if (hit_now && (stat.mode == MODE_FIND)) begin
							cmd.res_wr   = 1'b1;
							cmd.res_data = 1'b1;
							state_d      = S_DONE;
						end else if (stat.idx_last) begin
							cmd.res_wr = 1'b1;
							if (stat.found || hit_now) begin
								cmd.cnt_op = CNT_DEC;
							end else begin
								cmd.res_status = ST_NOT_FOUND;
							end
							state_d = S_DONE;
						end else begin
							cmd.idx_op = IDX_INC;
							state_d    = S_RD;
						end
					end
				endcase
			end
			S_INS: begin
				cmd.wr_op  = WR_NEW;
				cmd.cnt_op = CNT_INC;
				cmd.res_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!stat.rsp_busy) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PRQ_ASSERT_NEXT(a_accept_starts_op, (state_q == S_IDLE) && req_valid, state_q == S_CHK)
	`PRQ_ASSERT(a_load_only_when_free, cmd.load_rsp |-> !stat.rsp_busy)
	`PRQ_ASSERT(a_state_legal, state_q <= S_DONE)
	`PRQ_ASSERT(a_shift_after_pos, (cmd.wr_op == WR_SHIFT_UP) |-> stat.found)

endmodule

FILE: bench/priority_ready_queue_test.sv
// Self-checking bench for priority_ready_queue: an internal sorted-list model predicts each result.
// Directed corner cases, then phased random traffic, mostly with idle bursts on both channels.
// Depends on prq_pkg and the priority_ready_queue RTL.
module priority_ready_queue_test;
	import prq_pkg::*;

	localparam int DEPTH     = 32;
	localparam int PRIO_BITS = 8;
	localparam int WATCHDOG  = 4000;   // cycles with no item moving on either side
	localparam int TAIL_WAIT = 100;    // quiet cycles after the last result

	// modes the block takes but does nothing with
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// model of the slot list: head at 0, tail at slot_count-1
	logic [HANDLE_W-1:0]  slot_hdl [DEPTH];
	logic [PRIO_BITS-1:0] slot_pri [DEPTH];
	int                   slot_count = 0;

	rsp_item_t owed_results [$];   // one per accepted item, oldest first
	int        error_count = 0;
	bit        idle_on     = 1'b1; // random gaps / stalls allowed
	int        stall_left  = 0;
	int        quiet_cycles = 0;

	priority_ready_queue #(
		.DEPTH    (DEPTH),
		.PRIO_BITS(PRIO_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one operation to the model list and returns the result it owes.
	function automatic rsp_item_t apply_queue_op(input req_item_t it);
		rsp_item_t            r;
		int                   pos;
		int                   i;
		logic [PRIO_BITS-1:0] p;
		r   = '0;
		p   = it.item_priority[PRIO_BITS-1:0];
		pos = 0;
		case (it.mode)
			MODE_PUSH_HEAD, MODE_PUSH_PRIO: begin
				if (slot_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (it.mode == MODE_PUSH_HEAD) begin
						p = '0;
					end else begin
						// stop at first entry not above the new one: ties stay FIFO
						while (pos < slot_count && slot_pri[pos] > p)
							pos++;
					end
					for (i = slot_count; i > pos; i--) begin
						slot_hdl[i] = slot_hdl[i-1];
						slot_pri[i] = slot_pri[i-1];
					end
					slot_hdl[pos] = it.item_handle;
					slot_pri[pos] = p;
					slot_count++;
				end
			end
			MODE_POP: begin
				if (slot_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					slot_count--;
					r.out_handle   = slot_hdl[slot_count];
					r.out_priority = PRIO_IN_W'(slot_pri[slot_count]);
				end
			end
			MODE_FIND, MODE_REMOVE: begin
				while (pos < slot_count && slot_hdl[pos] != it.item_handle)
					pos++;
				if (pos >= slot_count) begin
					r.status = ST_NOT_FOUND;
				end else if (it.mode == MODE_FIND) begin
					r.out_handle   = slot_hdl[pos];
					r.out_priority = PRIO_IN_W'(slot_pri[pos]);
				end else begin
					// first match goes, later entries move up one slot
					for (i = pos; i + 1 < slot_count; i++) begin
						slot_hdl[i] = slot_hdl[i+1];
						slot_pri[i] = slot_pri[i+1];
					end
					slot_count--;
				end
			end
			default: begin
			end
		endcase
		r.occupancy = OCC_W'(slot_count);
		return r;
	endfunction

	// Presents one item, holds it through stalls, books its result on acceptance.
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] hdl,
			input logic [PRIO_IN_W-1:0] pri);
		req_item_t it;
		it.mode          = mode;
		it.item_handle   = hdl;
		it.item_priority = pri;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (req_stall);
		owed_results.push_back(apply_queue_op(it));
	endtask

	// Sender holds off until every booked result has come back.
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Handle drawn mostly from a small pool so finds and removes hit duplicates.
	function automatic logic [HANDLE_W-1:0] pick_handle(input bit prefer_present);
		if (prefer_present && slot_count > 0 && $urandom_range(0, 1) == 0)
			return slot_hdl[$urandom_range(0, slot_count - 1)];
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h0000_0001;
			3:       return 32'h8000_0000;
			4:       return 32'hA5A5_5A5A;
			5:       return 32'h0000_0042;
			6, 7:    return HANDLE_W'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// Priorities bunch near zero to force ties, with the top value and full range mixed in.
	function automatic logic [PRIO_IN_W-1:0] pick_priority();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return PRIO_IN_W'($urandom_range(0, 3));
			4:          return '1;
			default:    return PRIO_IN_W'($urandom);
		endcase
	endfunction

	// Empty queue: pop, find, remove and the spare modes, at field extremes and one mixed bit pattern.
	task automatic test_empty_queue();
		send_item(MODE_POP,         '1, '1);
		send_item(MODE_FIND,        '0, '0);
		send_item(MODE_REMOVE,      '1, '1);
		send_item(MODE_SPARE_FIRST, '1, '1);
		send_item(MODE_SPARE_MID,   '0, '0);
		send_item(MODE_SPARE_LAST,  32'h5A5A_A5A5, 8'hA5);
	endtask

	// Insertion order, ties, head push, find hit/miss, remove of first duplicate, pops.
	task automatic test_ordering();
		send_item(MODE_PUSH_PRIO, 32'h1, 8'd5);
		send_item(MODE_PUSH_PRIO, 32'h2, 8'd5);          // tie lands behind the first
		send_item(MODE_PUSH_PRIO, 32'h3, '1);            // top priority goes to head
		send_item(MODE_PUSH_PRIO, 32'h4, '0);
		send_item(MODE_PUSH_HEAD, '1, '1);               // priority ignored, forced to 0
		send_item(MODE_PUSH_PRIO, '0, '0);               // ties with the zero-priority head entry, lands at head
		send_item(MODE_FIND,      32'h2, '0);
		send_item(MODE_FIND,      32'h1234_5678, '0);    // absent
		send_item(MODE_FIND,      '1, '0);
		send_item(MODE_REMOVE,    32'h2, '0);            // from the middle
		send_item(MODE_REMOVE,    32'h3, '0);            // from the middle, behind the two zero entries
		send_item(MODE_PUSH_HEAD, 32'h1, '0);            // duplicate handle at head
		send_item(MODE_REMOVE,    32'h1, '0);            // takes the head copy
		send_item(MODE_FIND,      32'h1, '0);            // remaining copy keeps prio 5
		send_item(MODE_REMOVE,    32'h9999_9999, '0);    // absent
		repeat (4) send_item(MODE_POP, '0, '0);
		send_item(MODE_POP,       '0, '0);               // empty again
	endtask

	// Fill to the limit, bounce both push kinds off it, find the tail entry, then drain by pops.
	task automatic test_full_refusal();
		while (slot_count < DEPTH)
			send_item($urandom_range(0, 3) == 0 ? MODE_PUSH_HEAD : MODE_PUSH_PRIO,
				pick_handle(1'b0), pick_priority());
		send_item(MODE_PUSH_HEAD, '1, '1);
		send_item(MODE_PUSH_PRIO, '0, '1);
		send_item(MODE_FIND, slot_hdl[DEPTH-1], '0);
		while (slot_count > 0)
			send_item(MODE_POP, pick_handle(1'b0), pick_priority());
	endtask

	// Phases lean toward filling, draining or mixing; spare modes are noise and not counted.
	task automatic test_random_traffic(input int n_items);
		int                  done;
		int                  k;
		int                  phase_len;
		int                  push_w;
		int                  pop_w;
		int                  pct;
		logic [MODE_W-1:0]   mode;
		done = 0;
		while (done < n_items) begin
			phase_len = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0:       begin push_w = 75; pop_w = 10; end
				1:       begin push_w = 15; pop_w = 60; end
				default: begin push_w = 40; pop_w = 25; end
			endcase
			for (k = 0; k < phase_len && done < n_items; k++) begin
				pct = $urandom_range(0, 99);
				if (pct < push_w)
					mode = ($urandom_range(0, 3) == 0) ? MODE_PUSH_HEAD : MODE_PUSH_PRIO;
				else if (pct < push_w + pop_w)
					mode = MODE_POP;
				else if (pct < 96)
					mode = ($urandom_range(0, 1) == 0) ? MODE_FIND : MODE_REMOVE;
				else
					mode = MODE_SPARE_FIRST + MODE_W'($urandom_range(0, 2));
				send_item(mode, pick_handle(mode == MODE_FIND || mode == MODE_REMOVE),
					pick_priority());
				if (mode < MODE_SPARE_FIRST)
					done++;
			end
		end
	endtask

	// Receiver stalls in random bursts while idling is allowed.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			if (idle_on && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 16);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
			error_count++;
		end
	endtask

	// Every accepted result against the oldest booked one.
	always @(posedge clk) begin
		rsp_item_t exp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0h", $time, rsp);
				error_count++;
			end else begin
				exp = owed_results.pop_front();
				check_field("status",       32'(exp.status),       32'(rsp.status));
				check_field("out_handle",   exp.out_handle,        rsp.out_handle);
				check_field("out_priority", 32'(exp.out_priority), 32'(rsp.out_priority));
				check_field("occupancy",    32'(exp.occupancy),    32'(rsp.occupancy));
			end
		end
	end

	// Ends a hung run: nothing moved on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_ordering();
		wait_results_drained();
		test_full_refusal();
		test_random_traffic(1000);
		wait_results_drained();
		test_random_traffic(530);
		// last stretch runs at full rate on both sides
		idle_on = 1'b0;
		test_random_traffic(200);

		req_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
